>>> rtl/bdll_pkg.sv
// ----------------------------------------------------------------------------
// bdll_pkg: shared types and constants of the bounded doubly linked list
// Pool size, link encoding, action and status codes, controller commands.
// ----------------------------------------------------------------------------
package bdll_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int LINK_W      = $clog2(CAPACITY + 1);
    localparam int CNT_W       = LINK_W;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    localparam logic [2:0] ACT_PUSH_TAIL   = 3'd0;
    localparam logic [2:0] ACT_POP_TAIL    = 3'd1;
    localparam logic [2:0] ACT_REMOVE_HEAD = 3'd2;
    localparam logic [2:0] ACT_ADD_HEAD    = 3'd3;
    localparam logic [2:0] ACT_INSERT      = 3'd4;
    localparam logic [2:0] ACT_REMOVE      = 3'd5;
    localparam logic [2:0] ACT_READ        = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // controller to datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_INIT      = 4'd1;  // chain one free entry
    localparam logic [3:0] CMD_LOAD      = 4'd2;  // latch request, cur = head
    localparam logic [3:0] CMD_RD_CUR    = 4'd3;  // read links/value of cur
    localparam logic [3:0] CMD_STEP      = 4'd4;  // cur = next of cur
    localparam logic [3:0] CMD_LINK_A    = 4'd5;  // write new entry
    localparam logic [3:0] CMD_LINK_B    = 4'd6;  // patch neighbors
    localparam logic [3:0] CMD_DROP_A    = 4'd7;  // patch neighbors of cur
    localparam logic [3:0] CMD_DROP_B    = 4'd8;  // return cur to free list
    localparam logic [3:0] CMD_RESULT    = 4'd9;  // load output register
    localparam logic [3:0] CMD_SET_TAIL  = 4'd10; // cur = tail
    localparam logic [3:0] CMD_SET_NIL   = 4'd11; // cur = nil

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       with_data;
    } t_cmd;

    typedef struct packed {
        logic             init_done;
        logic             full;
        logic             empty;
        logic             idx_ge_cnt;
        logic             walk_done;
        logic             cur_nil;
        logic [2:0]       action;
    } t_stat;

endpackage

>>> rtl/bdll_if.sv
// ----------------------------------------------------------------------------
// bdll_if: valid/ready channel
// Carries one request or result with its payload.
// ----------------------------------------------------------------------------
interface bdll_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/bdll_datapath.sv
// ----------------------------------------------------------------------------
// bdll_datapath: link memories, pointers and output register
// Executes one controller command per cycle on the entry pool.
// ----------------------------------------------------------------------------
module bdll_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdll_pkg::t_cmd       i_cmd,
    input  logic [2:0]           i_action,
    input  logic [31:0]          i_value,
    input  logic [5:0]           i_index,
    output bdll_pkg::t_stat      o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [31:0]          o_data,
    output logic [6:0]           o_count
);
    import bdll_pkg::*;

    logic [VALUE_WIDTH-1:0] mem_val  [CAPACITY];
    logic [LINK_W-1:0]      mem_next [CAPACITY];
    logic [LINK_W-1:0]      mem_prev [CAPACITY];

    logic [LINK_W-1:0] r_head, r_tail, r_free, r_cur, r_new, r_before, r_at;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W:0]   r_init;
    logic [2:0]        r_action;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [5:0]        r_index, r_step;
    logic [LINK_W-1:0] r_cur_next, r_cur_prev;
    logic [VALUE_WIDTH-1:0] r_cur_val;
    logic [LINK_W-1:0] r_free_next;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [31:0]       r_data;

    logic [ADDR_W-1:0] cur_a;
    assign cur_a = r_cur[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NIL;
            r_tail <= NIL;
            r_free <= '0;
            r_count <= '0;
            r_init <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_cmd.op != CMD_RESULT) r_out_valid <= 1'b0;
            case (i_cmd.op)
                CMD_INIT: begin
                    mem_next[r_init[ADDR_W-1:0]] <= LINK_W'(r_init) + 1'b1;
                    r_init <= r_init + 1'b1;
                end
                CMD_LOAD: begin
                    r_action <= i_action;
                    r_value  <= i_value[VALUE_WIDTH-1:0];
                    r_index  <= i_index;
                    r_step   <= '0;
                    r_cur    <= r_head;
                    r_free_next <= mem_next[r_free[ADDR_W-1:0]];
                end
                CMD_SET_TAIL: r_cur <= r_tail;
                CMD_SET_NIL:  r_cur <= NIL;
                CMD_RD_CUR: begin
                    r_cur_next <= mem_next[cur_a];
                    r_cur_prev <= mem_prev[cur_a];
                    r_cur_val  <= mem_val[cur_a];
                end
                CMD_STEP: begin
                    r_cur  <= r_cur_next;
                    r_step <= r_step + 1'b1;
                end
                CMD_LINK_A: begin
                    // new entry goes in front of cur
                    r_new <= r_free;
                    r_at  <= r_cur;
                    r_before <= (r_cur == NIL) ? r_tail : r_cur_prev;
                    mem_val[r_free[ADDR_W-1:0]]  <= r_value;
                    mem_next[r_free[ADDR_W-1:0]] <= r_cur;
                    mem_prev[r_free[ADDR_W-1:0]] <= (r_cur == NIL) ? r_tail : r_cur_prev;
                    r_free  <= r_free_next;
                    r_count <= r_count + 1'b1;
                end
                CMD_LINK_B: begin
                    if (r_before == NIL) r_head <= r_new;
                    else mem_next[r_before[ADDR_W-1:0]] <= r_new;
                    if (r_at == NIL) r_tail <= r_new;
                    else mem_prev[r_at[ADDR_W-1:0]] <= r_new;
                end
                CMD_DROP_A: begin
                    if (r_cur_prev == NIL) r_head <= r_cur_next;
                    else mem_next[r_cur_prev[ADDR_W-1:0]] <= r_cur_next;
                    if (r_cur_next == NIL) r_tail <= r_cur_prev;
                    else mem_prev[r_cur_next[ADDR_W-1:0]] <= r_cur_prev;
                end
                CMD_DROP_B: begin
                    mem_next[cur_a] <= r_free;
                    r_free  <= r_cur;
                    r_count <= r_count - 1'b1;
                end
                CMD_RESULT: begin
                    r_out_valid <= 1'b1;
                    r_status <= i_cmd.status;
                    r_data   <= i_cmd.with_data ? 32'(signed'(r_cur_val)) : '0;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.init_done  = (r_init == (ADDR_W+1)'(CAPACITY));
    assign o_stat.full       = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.idx_ge_cnt = (CNT_W'(r_index) >= r_count);
    assign o_stat.walk_done  = (r_step == r_index);
    assign o_stat.cur_nil    = (r_cur == NIL);
    assign o_stat.action     = r_action;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_count     = 7'(r_count);

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
    a_empty_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NIL && r_tail == NIL))
        else $error("empty list with live pointers");
    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.init_done && r_count == CNT_W'(CAPACITY)) |-> (r_free == NIL))
        else $error("full list with free entries");
`endif
endmodule

>>> rtl/bdll_ctrl.sv
// ----------------------------------------------------------------------------
// bdll_ctrl: sequencer for list actions
// Runs the free list build after reset, then one request at a time.
// ----------------------------------------------------------------------------
module bdll_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdll_pkg::t_stat i_stat,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_busy,
    output bdll_pkg::t_cmd  o_cmd
);
    import bdll_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_DISP = 4'd2,
                           S_RD = 4'd3, S_WALK = 4'd4, S_LINKA = 4'd5,
                           S_LINKB = 4'd6, S_DROPA = 4'd7, S_DROPB = 4'd8,
                           S_DROPRD = 4'd9, S_OUT = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_st, n_st;
    logic       r_wd, n_wd;

    assign o_in_ready = (r_state == S_IDLE) && !i_out_busy;

    always_comb begin
        n_state = r_state;
        n_st = r_st;
        n_wd = r_wd;
        o_cmd = '{op: CMD_NONE, status: ST_OK, with_data: 1'b0};
        case (r_state)
            S_INIT: begin
                o_cmd.op = CMD_INIT;
                if (i_stat.init_done) begin
                    o_cmd.op = CMD_NONE;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: if (i_in_valid && o_in_ready) begin
                o_cmd.op = CMD_LOAD;
                n_state = S_DISP;
            end
            S_DISP: begin
                n_st = ST_OK;
                n_wd = 1'b0;
                n_state = S_OUT;
                case (i_stat.action)
                    ACT_PUSH_TAIL, ACT_ADD_HEAD, ACT_INSERT: begin
                        if (i_stat.full) n_st = ST_FULL;
                        else if (i_stat.action == ACT_ADD_HEAD) begin
                            o_cmd.op = CMD_RD_CUR; // cur is head
                            n_state = S_LINKA;
                        end else if (i_stat.action == ACT_PUSH_TAIL
                                     || i_stat.idx_ge_cnt) begin
                            o_cmd.op = CMD_SET_NIL;
                            n_state = S_LINKA;
                        end else n_state = S_WALK;
                    end
                    ACT_POP_TAIL, ACT_REMOVE_HEAD: begin
                        if (i_stat.empty) n_st = ST_EMPTY;
                        else begin
                            if (i_stat.action == ACT_POP_TAIL) o_cmd.op = CMD_SET_TAIL;
                            n_state = S_DROPRD;
                        end
                    end
                    ACT_REMOVE, ACT_READ: begin
                        if (i_stat.empty) n_st = ST_EMPTY;
                        else if (i_stat.idx_ge_cnt) n_st = ST_RANGE;
                        else n_state = S_WALK;
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                o_cmd.op = CMD_RD_CUR;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_stat.walk_done) begin
                    if (i_stat.action == ACT_INSERT) n_state = S_LINKA;
                    else if (i_stat.action == ACT_REMOVE) n_state = S_DROPA;
                    else begin
                        n_wd = 1'b1;
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.op = CMD_STEP;
                    n_state = S_WALK;
                end
            end
            S_DROPRD: begin
                o_cmd.op = CMD_RD_CUR;
                n_state = S_DROPA;
            end
            S_LINKA: begin
                o_cmd.op = CMD_LINK_A;
                n_state = S_LINKB;
            end
            S_LINKB: begin
                o_cmd.op = CMD_LINK_B;
                n_state = S_OUT;
            end
            S_DROPA: begin
                o_cmd.op = CMD_DROP_A;
                n_state = S_DROPB;
            end
            S_DROPB: begin
                o_cmd.op = CMD_DROP_B;
                n_wd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.op = CMD_RESULT;
                o_cmd.status = r_st;
                o_cmd.with_data = r_wd;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_st <= ST_OK;
            r_wd <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st <= n_st;
            r_wd <= n_wd;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_load_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_LOAD) |=> (r_state == S_DISP)) else $error("lost request");
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == CMD_RESULT) |=> (r_state == S_IDLE)) else $error("bad finish");
`endif
endmodule

>>> rtl/bounded_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list: doubly linked list over a 64-entry pool
// Seven list actions, one result per request, valid/ready channels.
// ----------------------------------------------------------------------------
// After reset the block chains the free list and accepts no request until
// that is done. Requests are handled one at a time. Push tail, add head and
// an appending insert link a free entry without a walk; pop tail and remove
// head read the end entry and unlink it; a request refused for an empty or
// full list or a bad index, or the unused code, goes straight to the result.
// Positional actions walk the links one entry at a time from the head,
// reading each entry and stepping to its next; insert and remove then link
// or unlink at the index, read returns its value. The result waits in an
// output register; the next request is taken no earlier than the cycle after
// it has been delivered.
module bounded_doubly_linked_list (
    input  logic i_clk,
    input  logic i_rst_n,
    bdll_if.sink   i_req,
    bdll_if.source o_res
);
    import bdll_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_valid;
    logic [1:0]  st;
    logic [31:0] dat;
    logic [6:0]  cnt;

    bdll_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stat(stat),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .i_out_busy(out_valid), .o_cmd(cmd)
    );

    bdll_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_action(i_req.payload[40:38]), .i_value(i_req.payload[37:6]),
        .i_index(i_req.payload[5:0]), .o_stat(stat),
        .i_out_ready(o_res.ready), .o_out_valid(out_valid),
        .o_status(st), .o_data(dat), .o_count(cnt)
    );

    assign o_res.valid   = out_valid;
    assign o_res.payload = {st, dat, cnt};
endmodule
